// ===== hw/rtl/olist_pkg.sv =====
// Package: action and status codes, payload types and the cell command struct.
package olist_pkg;

   localparam int ACTION_W   = 3;
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 4;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;

   typedef logic [ACTION_W-1:0]          action_type;
   typedef logic signed [VALUE_W-1:0]    value_type;
   typedef logic [POSITION_W-1:0]        position_type;
   typedef logic [STATUS_W-1:0]          status_type;
   typedef logic [COUNT_W-1:0]           count_type;

   localparam action_type ACT_INS_HEAD = 3'd0;
   localparam action_type ACT_INS_TAIL = 3'd1;
   localparam action_type ACT_RM_HEAD  = 3'd2;
   localparam action_type ACT_RM_TAIL  = 3'd3;
   localparam action_type ACT_RM_INDEX = 3'd4;
   localparam action_type ACT_GET      = 3'd5;
   localparam action_type ACT_RM_VALUE = 3'd6;
   localparam action_type ACT_CLEAR    = 3'd7;

   localparam status_type ST_OK   = 2'd0;
   localparam status_type ST_MISS = 2'd1;
   localparam status_type ST_FULL = 2'd2;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic         go;
      action_type   action;
      value_type    value;
      position_type position;
   } cmd_type;

   // Per-cell view of the list occupancy
   typedef struct packed {
      logic in_list;
      logic at_tail;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/olist_if.sv =====
// Interfaces: request and response channels of the ordered list engine.
interface olist_req_if;
   logic                    valid;
   logic                    ready;
   olist_pkg::action_type   action;
   olist_pkg::value_type    value;
   olist_pkg::position_type position;

   modport source (output valid, action, value, position, input ready);
   modport sink   (input valid, action, value, position, output ready);
endinterface

interface olist_rsp_if;
   logic                  valid;
   logic                  ready;
   olist_pkg::status_type status;
   olist_pkg::value_type  data;
   olist_pkg::count_type  count;

   modport source (output valid, status, data, count, input ready);
   modport sink   (input valid, status, data, count, output ready);
endinterface

// ===== hw/rtl/olist_cell.sv =====
// List cell: holds one entry, shifts toward head or tail and matches by value.
module olist_cell #(
   parameter int INDEX = 0
) (
   input  logic                    clock,
   input  olist_pkg::cmd_type      cmd,
   input  olist_pkg::cell_ctl_type ctl,
   input  olist_pkg::value_type    left_data,
   input  olist_pkg::value_type    right_data,
   input  logic                    found_in,
   output logic                    found_out,
   output olist_pkg::value_type    data
);

   localparam logic [olist_pkg::POSITION_W-1:0] IDX_LO = INDEX[olist_pkg::POSITION_W-1:0];
   localparam bit BEYOND_POS = (INDEX >= (1 << olist_pkg::POSITION_W));

   olist_pkg::value_type data_ff, data_in;
   logic hit;
   logic at_or_after_pos;

   // Match only live entries; pass the first-match flag down the chain
   assign hit       = ctl.in_list && (data_ff == cmd.value);
   assign found_out = found_in || hit;
   assign at_or_after_pos = BEYOND_POS || (IDX_LO >= cmd.position);

   // Pick the next entry for this cell
   always_comb begin
      data_in = data_ff;
      if (cmd.go) begin
         unique case (cmd.action)
            olist_pkg::ACT_INS_HEAD: data_in = left_data;
            olist_pkg::ACT_INS_TAIL: if (ctl.at_tail) data_in = cmd.value;
            olist_pkg::ACT_RM_HEAD:  data_in = right_data;
            olist_pkg::ACT_RM_INDEX: if (at_or_after_pos) data_in = right_data;
            olist_pkg::ACT_RM_VALUE: if (found_out) data_in = right_data;
            default:                 data_in = data_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== hw/rtl/ordered_list_engine_top.sv =====
// Top level: ordered list engine built as a chain of entry cells.
//
// Ordered list of up to DEPTH signed 32-bit values, index 0 at the head.
// The req channel carries one action per item (insert head/tail, remove
// head/tail/at position/by value, read at position, clear) with its value
// and position. The rsp channel returns exactly one item per request: a
// status, a data word and the entry count after the action.
// Every cell of the chain compares and shifts in the same cycle, so an
// action completes at once: its result is registered and appears on
// rsp in the cycle after the request is taken. A new request is taken in
// every cycle in which the result register is empty or being drained, so
// sustained throughput is one item per cycle. Remove-by-value resolves the
// first match through a found flag passed from cell to cell along the chain.
// When the receiver stalls, the result holds on rsp and req.ready stays low
// until it is taken. Reset (synchronous, active high) empties the list and
// drops any pending result; entry storage is not cleared and needs no
// clearing pass.
module ordered_list_engine_top #(
   parameter int DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   olist_req_if.sink  req,
   olist_rsp_if.source rsp
);

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int RD_N = (DEPTH < 16) ? DEPTH : 16;

   typedef logic [CW-1:0] cnt_type;

   cnt_type count_ff, count_in;
   logic    rsp_valid_ff, rsp_valid_in;
   olist_pkg::status_type status_ff, status_in;
   olist_pkg::value_type  data_ff, data_in;
   olist_pkg::count_type  rcount_ff;

   logic accept;
   logic list_full, list_empty, pos_miss, value_found, ok;
   olist_pkg::value_type read_data;
   olist_pkg::cmd_type cmd;
   olist_pkg::value_type entry [DEPTH];
   logic [DEPTH:0] found;
   logic [CW+4:0] count_wide;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign list_full  = (count_ff == CW'(DEPTH));
   assign list_empty = (count_ff == '0);
   assign pos_miss   = ({{CW{1'b0}}, req.position} >= {{olist_pkg::POSITION_W{1'b0}}, count_ff});
   assign value_found = found[DEPTH];

   // Decide whether the action succeeds
   always_comb begin
      unique case (req.action)
         olist_pkg::ACT_INS_HEAD, olist_pkg::ACT_INS_TAIL: ok = !list_full;
         olist_pkg::ACT_RM_HEAD,  olist_pkg::ACT_RM_TAIL:  ok = !list_empty;
         olist_pkg::ACT_RM_INDEX, olist_pkg::ACT_GET:      ok = !pos_miss;
         olist_pkg::ACT_RM_VALUE:                          ok = value_found;
         default:                                          ok = 1'b1;
      endcase
   end

   assign cmd.go       = accept && ok;
   assign cmd.action   = req.action;
   assign cmd.value    = req.value;
   assign cmd.position = req.position;

   // Build the chain of cells
   assign found[0] = 1'b0;
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      olist_pkg::cell_ctl_type ctl;
      olist_pkg::value_type    left_d, right_d;
      assign ctl.in_list = (CW'(i) < count_ff);
      assign ctl.at_tail = (CW'(i) == count_ff);
      if (i == 0) begin : g_head
         assign left_d = req.value;
      end else begin : g_mid
         assign left_d = entry[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_d = entry[i];
      end else begin : g_body
         assign right_d = entry[i+1];
      end
      olist_cell #(.INDEX(i)) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .ctl        (ctl),
         .left_data  (left_d),
         .right_data (right_d),
         .found_in   (found[i]),
         .found_out  (found[i+1]),
         .data       (entry[i])
      );
   end

   // Select the entry addressed by position
   always_comb begin
      read_data = '0;
      for (int i = 0; i < RD_N; i++) begin
         if (req.position == olist_pkg::POSITION_W'(i)) read_data = entry[i];
      end
   end

   // Work out the new count and the result word
   always_comb begin
      count_in  = count_ff;
      status_in = olist_pkg::ST_OK;
      data_in   = '0;
      unique case (req.action)
         olist_pkg::ACT_INS_HEAD, olist_pkg::ACT_INS_TAIL: begin
            if (ok) begin
               count_in = count_ff + CW'(1);
               data_in  = req.value;
            end else begin
               status_in = olist_pkg::ST_FULL;
            end
         end
         olist_pkg::ACT_RM_HEAD, olist_pkg::ACT_RM_TAIL, olist_pkg::ACT_RM_INDEX: begin
            if (ok) begin
               count_in = count_ff - CW'(1);
               data_in  = olist_pkg::VALUE_W'(count_in);
            end else begin
               status_in = olist_pkg::ST_MISS;
            end
         end
         olist_pkg::ACT_GET: begin
            if (ok) data_in = read_data;
            else    status_in = olist_pkg::ST_MISS;
         end
         olist_pkg::ACT_RM_VALUE: begin
            if (ok) begin
               count_in = count_ff - CW'(1);
               data_in  = req.value;
            end else begin
               status_in = olist_pkg::ST_MISS;
            end
         end
         default: count_in = '0;
      endcase
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);
   assign count_wide   = {5'b0, count_in};

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) count_ff <= count_in;
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         data_ff   <= data_in;
         rcount_ff <= count_wide[4:0];
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.status = status_ff;
   assign rsp.data   = data_ff;
   assign rsp.count  = rcount_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("list count beyond depth");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && count_ff == '0))
      else $error("reset left a result or entries");

   a_full_insert: assert property (@(posedge clock) disable iff (reset)
      (accept && list_full && (req.action == olist_pkg::ACT_INS_HEAD ||
       req.action == olist_pkg::ACT_INS_TAIL))
      |=> (status_ff == olist_pkg::ST_FULL && count_ff == $past(count_ff)))
      else $error("insert into full list not refused");

   a_rm_tail: assert property (@(posedge clock) disable iff (reset)
      (accept && !list_empty && req.action == olist_pkg::ACT_RM_TAIL)
      |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("remove tail did not shrink list");

endmodule

// ===== tb/ordered_list_engine_top_tb.sv =====
// Testbench: ordered list engine driven over req/rsp and checked against a list predictor.
`timescale 1ns / 1ps

module ordered_list_engine_top_tb;

   localparam int LIST_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 850;
   localparam int QUIET_LIMIT = 2000;
   localparam int STALL_PCT   = 9;
   localparam int HOLD_CYCLES = 80;
   localparam int HOLD_AFTER  = 300;

   typedef enum {CHURN_GROW, CHURN_SHRINK, CHURN_MIX} churn_mode_type;

   // Predicts each list action and checks the responses in order
   class list_scoreboard;
      typedef struct {
         olist_pkg::status_type status;
         olist_pkg::value_type  data;
         olist_pkg::count_type  count;
      } list_outcome_type;

      olist_pkg::value_type cells[LIST_DEPTH];
      int                   used;
      list_outcome_type     outcomes_due[$];
      int                   errors;

      function new();
         used   = 0;
         errors = 0;
      endfunction

      // Close the gap left at idx by shifting the tail toward the head
      function void drop_cell(int idx);
         for (int i = idx; i + 1 < used; i++)
            cells[i] = cells[i + 1];
         used--;
      endfunction

      // Apply one accepted action and queue the response it must produce
      function void apply_action(olist_pkg::action_type act, olist_pkg::value_type val,
                                 olist_pkg::position_type pos);
         list_outcome_type res;
         res.status = olist_pkg::ST_OK;
         res.data   = '0;
         case (act)
            olist_pkg::ACT_INS_HEAD: begin
               if (used >= LIST_DEPTH) begin
                  res.status = olist_pkg::ST_FULL;
               end else begin
                  for (int i = used; i > 0; i--)
                     cells[i] = cells[i - 1];
                  cells[0] = val;
                  used++;
                  res.data = val;
               end
            end
            olist_pkg::ACT_INS_TAIL: begin
               if (used >= LIST_DEPTH) begin
                  res.status = olist_pkg::ST_FULL;
               end else begin
                  cells[used] = val;
                  used++;
                  res.data = val;
               end
            end
            olist_pkg::ACT_RM_HEAD: begin
               if (used == 0) begin
                  res.status = olist_pkg::ST_MISS;
               end else begin
                  drop_cell(0);
                  res.data = olist_pkg::value_type'(used);
               end
            end
            olist_pkg::ACT_RM_TAIL: begin
               if (used == 0) begin
                  res.status = olist_pkg::ST_MISS;
               end else begin
                  used--;
                  res.data = olist_pkg::value_type'(used);
               end
            end
            olist_pkg::ACT_RM_INDEX: begin
               if (int'(pos) >= used) begin
                  res.status = olist_pkg::ST_MISS;
               end else begin
                  drop_cell(int'(pos));
                  res.data = olist_pkg::value_type'(used);
               end
            end
            olist_pkg::ACT_GET: begin
               if (int'(pos) >= used)
                  res.status = olist_pkg::ST_MISS;
               else
                  res.data = cells[pos];
            end
            olist_pkg::ACT_RM_VALUE: begin
               res.status = olist_pkg::ST_MISS;
               for (int i = 0; i < used; i++) begin
                  if (cells[i] == val) begin
                     drop_cell(i);
                     res.status = olist_pkg::ST_OK;
                     res.data   = val;
                     break;
                  end
               end
            end
            default: begin
               used = 0;
            end
         endcase
         res.count = olist_pkg::count_type'(used);
         outcomes_due.push_back(res);
      endfunction

      // Compare one response with the oldest prediction, field by field
      function void check_response(olist_pkg::status_type st, olist_pkg::value_type dat,
                                   olist_pkg::count_type cnt);
         list_outcome_type want;
         if (outcomes_due.size() == 0) begin
            $display("%0t: unexpected response status %0d data %0d count %0d",
                     $time, st, dat, cnt);
            errors++;
            return;
         end
         want = outcomes_due.pop_front();
         if (st !== want.status) begin
            $display("%0t: status mismatch expected %0d actual %0d", $time, want.status, st);
            errors++;
         end
         if (dat !== want.data) begin
            $display("%0t: data mismatch expected %0d actual %0d", $time, want.data, dat);
            errors++;
         end
         if (cnt !== want.count) begin
            $display("%0t: count mismatch expected %0d actual %0d", $time, want.count, cnt);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   olist_req_if req_ch ();
   olist_rsp_if rsp_ch ();

   ordered_list_engine_top #(.DEPTH(LIST_DEPTH)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   list_scoreboard sb;
   bit  calm;
   int  rsp_taken;
   int  quiet_cycles;

   // Clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Offer one item after a random idle gap and hold it until accepted
   task automatic send_item(olist_pkg::action_type act, olist_pkg::value_type val,
                            olist_pkg::position_type pos);
      while (!calm && $urandom_range(99) < STALL_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.action   <= act;
      req_ch.value    <= val;
      req_ch.position <= pos;
      do @(posedge clock); while (!req_ch.ready);
      sb.apply_action(act, val, pos);
      @(negedge clock);
   endtask

   // Pick a value: often from a small pool so removals by value hit, some extremes
   function automatic olist_pkg::value_type pick_value();
      int r;
      r = $urandom_range(9);
      if (r < 4)
         return olist_pkg::value_type'($urandom_range(7));
      if (r < 6) begin
         case ($urandom_range(3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -1;
            default: return '0;
         endcase
      end
      return olist_pkg::value_type'($urandom);
   endfunction

   // Response monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_response(rsp_ch.status, rsp_ch.data, rsp_ch.count);
            rsp_taken++;
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("tb: failure");
               $finish;
            end
         end
      end
   end

   // Receiver: random stalls, one long hold-off to back up the input
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (!hold_done && rsp_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= STALL_PCT);
         end
      end
   end

   // Stimulus and end of run
   initial begin
      churn_mode_type          mode;
      olist_pkg::action_type   act;
      olist_pkg::value_type    val;
      olist_pkg::position_type pos;
      int                      r;

      sb           = new();
      calm         = 1'b0;
      rsp_taken    = 0;
      quiet_cycles = 0;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.action   = olist_pkg::ACT_INS_HEAD;
      req_ch.value    = '0;
      req_ch.position = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty list: every removal and read misses, clear still succeeds
      send_item(olist_pkg::ACT_RM_HEAD,  0, 0);
      send_item(olist_pkg::ACT_RM_TAIL,  0, 0);
      send_item(olist_pkg::ACT_RM_INDEX, 0, 0);
      send_item(olist_pkg::ACT_GET,      0, 0);
      send_item(olist_pkg::ACT_RM_VALUE, 0, 0);
      send_item(olist_pkg::ACT_CLEAR,    0, 0);
      // One-entry list: remove tail, then remove by value
      send_item(olist_pkg::ACT_INS_TAIL, 32'sh7fff_ffff, 4'hf);
      send_item(olist_pkg::ACT_RM_TAIL,  0, 0);
      send_item(olist_pkg::ACT_INS_HEAD, 32'sh8000_0000, 0);
      send_item(olist_pkg::ACT_RM_VALUE, 32'sh8000_0000, 0);
      // Build 0 1 2 3, then reads, removals by value at head and tail, and removals by index
      send_item(olist_pkg::ACT_INS_TAIL, 1, 0);
      send_item(olist_pkg::ACT_INS_TAIL, 2, 0);
      send_item(olist_pkg::ACT_INS_TAIL, 3, 0);
      send_item(olist_pkg::ACT_INS_HEAD, 0, 0);
      send_item(olist_pkg::ACT_GET,      0, 3);
      send_item(olist_pkg::ACT_GET,      0, 4);
      send_item(olist_pkg::ACT_RM_VALUE, 0, 0);
      send_item(olist_pkg::ACT_RM_VALUE, 3, 0);
      send_item(olist_pkg::ACT_RM_VALUE, 99, 0);
      send_item(olist_pkg::ACT_RM_INDEX, 0, 1);
      send_item(olist_pkg::ACT_RM_INDEX, 0, 4'hf);
      send_item(olist_pkg::ACT_RM_HEAD,  0, 0);
      send_item(olist_pkg::ACT_CLEAR,    0, 0);

      // Random churn: phases that mostly grow, mostly drain, or mix
      mode = CHURN_GROW;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 400 && n < 550);
         if (n % 40 == 0)
            mode = churn_mode_type'($urandom_range(2));
         r = $urandom_range(99);
         if (mode == CHURN_GROW && r < 70) begin
            act = $urandom_range(1) ? olist_pkg::ACT_INS_TAIL : olist_pkg::ACT_INS_HEAD;
         end else if (mode == CHURN_SHRINK && r < 70) begin
            case ($urandom_range(3))
               0:       act = olist_pkg::ACT_RM_HEAD;
               1:       act = olist_pkg::ACT_RM_TAIL;
               2:       act = olist_pkg::ACT_RM_INDEX;
               default: act = olist_pkg::ACT_RM_VALUE;
            endcase
         end else begin
            act = olist_pkg::action_type'($urandom_range(olist_pkg::ACT_RM_VALUE,
                                                         olist_pkg::ACT_INS_HEAD));
         end
         if ($urandom_range(59) == 0)
            act = olist_pkg::ACT_CLEAR;

         val = pick_value();
         if (act == olist_pkg::ACT_RM_VALUE && sb.used > 0 && $urandom_range(3) != 0)
            val = sb.cells[$urandom_range(sb.used - 1)];

         if (sb.used > 0 && $urandom_range(9) < 7)
            pos = olist_pkg::position_type'($urandom_range(sb.used - 1));
         else
            pos = olist_pkg::position_type'($urandom_range(LIST_DEPTH - 1));

         send_item(act, val, pos);
      end
      calm = 1'b0;
      req_ch.valid <= 1'b0;

      // Drain, then wait for any stray response
      while (sb.outcomes_due.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
